// ----- rtl/utf8_cluster_display_width_macros.svh -----
// ----------------------------------------------------------------------------
// utf8_cluster_display_width assertion macros
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef UTF8_CLUSTER_DISPLAY_WIDTH_MACROS_SVH
`define UTF8_CLUSTER_DISPLAY_WIDTH_MACROS_SVH

// Property checked on every clock edge, masked while reset is asserted.
`define U8CDW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define U8CDW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/u8cdw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cdw_pkg
// Shared types, constants and the column width lookup for the UTF-8
// cluster display width block.
// ----------------------------------------------------------------------------
package u8cdw_pkg;

  localparam int CP_W = 21;

  localparam logic [7:0] LEAD_2B_LIMIT = 8'hE0;
  localparam logic [7:0] LEAD_3B_LIMIT = 8'hF0;
  localparam logic [7:0] LEAD_1B_LIMIT = 8'h80;

  localparam logic [CP_W-1:0] CP_VS16    = 21'h00FE0F;
  localparam logic [CP_W-1:0] CP_CTRL_LT = 21'h000020;

  localparam logic [1:0] COLS_ZERO   = 2'd0;
  localparam logic [1:0] COLS_NARROW = 2'd1;
  localparam logic [1:0] COLS_WIDE   = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } cp_range_t;

  // Decoded event handed from the front end to the back end.
  typedef struct packed {
    logic            has_cp;  // a codepoint completed on this byte
    logic            last;    // byte closed the cluster
    logic [CP_W-1:0] cp;
  } ev_t;

  localparam int N_ZERO = 9;
  localparam int N_WIDE = 12;

  localparam cp_range_t ZERO_RANGES [N_ZERO] = '{
    '{21'h000300, 21'h00036F}, '{21'h001AB0, 21'h001AFF}, '{21'h001DC0, 21'h001DFF},
    '{21'h0020D0, 21'h0020FF}, '{21'h00FE00, 21'h00FE0F}, '{21'h00FE20, 21'h00FE2F},
    '{21'h0E0100, 21'h0E01EF}, '{21'h00200B, 21'h00200D}, '{21'h00FEFF, 21'h00FEFF}
  };

  localparam cp_range_t WIDE_RANGES [N_WIDE] = '{
    '{21'h001100, 21'h00115F}, '{21'h002E80, 21'h00303E}, '{21'h003040, 21'h0033BF},
    '{21'h00F900, 21'h00FAFF}, '{21'h00FE30, 21'h00FE6F}, '{21'h00FF01, 21'h00FF60},
    '{21'h00FFE0, 21'h00FFE6}, '{21'h020000, 21'h02FFFF}, '{21'h030000, 21'h03FFFF},
    '{21'h01F000, 21'h01FFFF}, '{21'h004E00, 21'h009FFF}, '{21'h003400, 21'h004DBF}
  };

  // Terminal columns of one codepoint; range compares run in parallel.
  function automatic logic [1:0] column_width(input logic [CP_W-1:0] cp);
    logic zero_hit;
    logic wide_hit;
    logic [1:0] w;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      if (cp >= ZERO_RANGES[i].lo && cp <= ZERO_RANGES[i].hi) zero_hit = 1'b1;
    end
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_RANGES[i].lo && cp <= WIDE_RANGES[i].hi) wide_hit = 1'b1;
    end
    if (cp == '0 || zero_hit) begin
      w = COLS_ZERO;
    end else if (wide_hit) begin
      w = COLS_WIDE;
    end else if (cp < CP_CTRL_LT) begin
      w = COLS_ZERO;
    end else begin
      w = COLS_NARROW;
    end
    return w;
  endfunction

endpackage

// ----- rtl/u8cdw_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cdw_fifo
// Small register-based queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module u8cdw_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/u8cdw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cdw_front
// Byte intake: classifies lead bytes, gathers continuation bits and emits
// an event for each completed codepoint or cluster end.
// ----------------------------------------------------------------------------
module u8cdw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  input  logic              last_byte,
  output logic              ev_push,
  output u8cdw_pkg::ev_t    ev
);

  import u8cdw_pkg::*;

  logic [1:0]      bytes_pending_r, bytes_pending_nxt;
  logic [CP_W-1:0] code_accum_r, code_accum_nxt;
  logic [CP_W-1:0] cont_cp;

  assign cont_cp = {code_accum_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    bytes_pending_nxt = bytes_pending_r;
    code_accum_nxt    = code_accum_r;
    ev.has_cp         = 1'b0;
    ev.last           = last_byte;
    ev.cp             = cont_cp;
    if (bytes_pending_r == 2'd0) begin
      ev.cp = {13'd0, byte_in};
      if (byte_in < LEAD_1B_LIMIT) begin
        ev.has_cp = 1'b1;
      end else if (byte_in < LEAD_2B_LIMIT) begin
        code_accum_nxt    = {16'd0, byte_in[4:0]};
        bytes_pending_nxt = 2'd1;
      end else if (byte_in < LEAD_3B_LIMIT) begin
        code_accum_nxt    = {17'd0, byte_in[3:0]};
        bytes_pending_nxt = 2'd2;
      end else begin
        code_accum_nxt    = {18'd0, byte_in[2:0]};
        bytes_pending_nxt = 2'd3;
      end
    end else begin
      code_accum_nxt    = cont_cp;
      bytes_pending_nxt = bytes_pending_r - 1'b1;
      ev.has_cp         = (bytes_pending_r == 2'd1);
    end
    // cluster end drops any partial codepoint
    if (last_byte) begin
      bytes_pending_nxt = 2'd0;
      code_accum_nxt    = '0;
    end
  end

  assign ev_push = accept && (ev.has_cp || ev.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_pending_r <= 2'd0;
      code_accum_r    <= '0;
    end else if (accept) begin
      bytes_pending_r <= bytes_pending_nxt;
      code_accum_r    <= code_accum_nxt;
    end
  end

endmodule

// ----- rtl/u8cdw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cdw_back
// Width engine: looks up the first codepoint, applies the emoji
// presentation selector and issues the width at cluster end.
// ----------------------------------------------------------------------------
module u8cdw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8cdw_pkg::ev_t    ev,
  input  logic              ev_empty,
  output logic              ev_pop,
  input  logic              res_full,
  output logic              res_push,
  output logic [1:0]        res_columns
);

  import u8cdw_pkg::*;

  logic       base_seen_r, base_seen_nxt;
  logic [1:0] width_so_far_r, width_so_far_nxt;
  logic [1:0] w_after;
  logic       base_after;

  // an end-of-cluster event waits for room in the result queue
  assign ev_pop   = !ev_empty && (!ev.last || !res_full);
  assign res_push = ev_pop && ev.last;

  always_comb begin
    w_after = width_so_far_r;
    if (ev.has_cp && !base_seen_r) begin
      w_after = column_width(ev.cp);
    end else if (ev.has_cp && ev.cp == CP_VS16 && width_so_far_r == COLS_NARROW) begin
      w_after = COLS_WIDE;
    end
    base_after  = base_seen_r | ev.has_cp;
    // a first codepoint cut off reads as the replacement character
    res_columns = base_after ? w_after : COLS_NARROW;
  end

  always_comb begin
    base_seen_nxt    = base_seen_r;
    width_so_far_nxt = width_so_far_r;
    if (ev_pop) begin
      if (ev.last) begin
        base_seen_nxt    = 1'b0;
        width_so_far_nxt = COLS_ZERO;
      end else begin
        base_seen_nxt    = base_after;
        width_so_far_nxt = w_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seen_r    <= 1'b0;
      width_so_far_r <= COLS_ZERO;
    end else begin
      base_seen_r    <= base_seen_nxt;
      width_so_far_r <= width_so_far_nxt;
    end
  end

endmodule

// ----- rtl/utf8_cluster_display_width.sv -----
`timescale 1ns / 1ps
// Path: a cluster's last byte is registered into the event queue; the width
//   engine then pushes its width into the result queue once that has room.
// Throughput: one byte per cycle while the event queue has room; results drain
//   at one per cycle.
// Reset: synchronous, active low; clears decode state, width state and queues.
// ----------------------------------------------------------------------------
// utf8_cluster_display_width
// Terminal column width of a UTF-8 cluster, fed one byte per transaction.
// ----------------------------------------------------------------------------
module utf8_cluster_display_width #(
  parameter int EV_DEPTH  = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte intake queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_columns
);

  import u8cdw_pkg::*;

  // Structure:
  //   front  - decodes lead/continuation bytes, one per cycle if evq has room;
  //            only completed codepoints and cluster ends become events
  //   evq    - event queue decoupling decode from the width lookup
  //   back   - range-table lookup of the first codepoint, selector upgrade,
  //            and result generation on the cluster end
  //   resq   - result queue; the back end stalls only on a cluster end
  //            when it is full, while the front takes bytes until evq is full

  localparam int EV_W = $bits(ev_t);

  logic            accept;
  logic            ev_push;
  ev_t             ev_in;
  logic            ev_full;
  logic            ev_empty;
  logic            ev_pop;
  logic [EV_W-1:0] ev_head_bits;
  ev_t             ev_head;
  logic            res_push;
  logic            res_full;
  logic [1:0]      res_columns;

  // Input is held off whenever the event queue has no room, even for bytes
  // that would produce no event; keeps the ready path a plain flop compare.
  assign full   = ev_full;
  assign accept = push && !ev_full;

  u8cdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .ev_push   (ev_push),
    .ev        (ev_in)
  );

  u8cdw_fifo #(
    .DEPTH (EV_DEPTH),
    .WIDTH (EV_W)
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .din   (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .dout  (ev_head_bits),
    .empty (ev_empty)
  );

  assign ev_head = ev_t'(ev_head_bits);

  u8cdw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev          (ev_head),
    .ev_empty    (ev_empty),
    .ev_pop      (ev_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_columns (res_columns)
  );

  // Result queue: the head entry is what the consumer sees while not empty.
  u8cdw_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (2)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_columns),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_columns),
    .empty (empty)
  );

endmodule

// ----- rtl/u8cdw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cdw_checker
// Port-level checks for the UTF-8 cluster display width block.
// ----------------------------------------------------------------------------
`include "utf8_cluster_display_width_macros.svh"

module u8cdw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_columns
);

  // reset leaves both queues drained: nothing to pop, room to push
  `U8CDW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (empty && !full), "queues not clear after reset")

  // widths are never three columns
  `U8CDW_ASSERT(a_cols_range, clk, rst_n, !empty |-> (out_columns != 2'd3), "columns out of range")

  // a waiting result stays put until popped
  `U8CDW_ASSERT(a_res_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_columns)), "result changed while stalled")

endmodule

bind utf8_cluster_display_width u8cdw_checker u_chk (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_cluster_display_width. Clusters of bytes,
// directed first and then random (mostly well-formed UTF-8 with random
// codepoints, plus cut-off, malformed and noise clusters), are pushed one
// byte per transaction. A cycle-free predictor tracks the decode state and
// queues the expected column count on every last byte; the monitor checks
// each popped result against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
  import u8cdw_pkg::*;

  // One byte transaction waiting to be sent. hold makes the driver wait for
  // every outstanding width to drain before it offers this byte.
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         hold;
  } byte_xfer_t;

  localparam int N_MARK   = 9;
  localparam int N_DOUBLE = 12;
  localparam int CALM_TAIL = 150;   // no idling once this few bytes remain

  // Zero-width codepoint ranges (combining marks, selectors, joiners, BOM).
  localparam logic [20:0] MARK_LO [N_MARK] = '{
    21'h000300, 21'h001AB0, 21'h001DC0, 21'h00200B, 21'h0020D0,
    21'h00FE00, 21'h00FE20, 21'h00FEFF, 21'h0E0100
  };
  localparam logic [20:0] MARK_HI [N_MARK] = '{
    21'h00036F, 21'h001AFF, 21'h001DFF, 21'h00200D, 21'h0020FF,
    21'h00FE0F, 21'h00FE2F, 21'h00FEFF, 21'h0E01EF
  };
  // Double-width ranges (Hangul jamo, CJK, fullwidth forms, emoji planes).
  localparam logic [20:0] DOUBLE_LO [N_DOUBLE] = '{
    21'h001100, 21'h002E80, 21'h003040, 21'h003400, 21'h004E00, 21'h00F900,
    21'h00FE30, 21'h00FF01, 21'h00FFE0, 21'h01F000, 21'h020000, 21'h030000
  };
  localparam logic [20:0] DOUBLE_HI [N_DOUBLE] = '{
    21'h00115F, 21'h00303E, 21'h0033BF, 21'h004DBF, 21'h009FFF, 21'h00FAFF,
    21'h00FE6F, 21'h00FF60, 21'h00FFE6, 21'h01FFFF, 21'h02FFFF, 21'h03FFFF
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_in = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_columns;

  byte_xfer_t byte_stream [$];     // bytes still to be sent
  logic [7:0] cluster_bytes [$];   // cluster under construction
  logic [1:0] width_q [$];         // expected column counts, oldest first
  int         mismatches = 0;
  int         send_idle = 0;
  int         recv_idle = 0;

  // Predictor state: mirrors the decoder between bytes of one cluster.
  logic [1:0]  dec_pending = 2'd0;
  logic [20:0] dec_cp = '0;
  bit          dec_base_seen = 1'b0;
  logic [1:0]  dec_cols = COLS_ZERO;

  utf8_cluster_display_width dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .empty        (empty),
    .pop          (pop),
    .out_columns  (out_columns)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] cols_for_codepoint(input logic [20:0] cp);
    if (cp == '0) return COLS_ZERO;
    for (int i = 0; i < N_MARK; i++) begin
      if (cp >= MARK_LO[i] && cp <= MARK_HI[i]) return COLS_ZERO;
    end
    for (int i = 0; i < N_DOUBLE; i++) begin
      if (cp >= DOUBLE_LO[i] && cp <= DOUBLE_HI[i]) return COLS_WIDE;
    end
    // C0 controls take no columns
    if (cp < 21'h000020) return COLS_ZERO;
    return COLS_NARROW;
  endfunction

  // Only the first codepoint sets the width; a later VS16 widens narrow to 2.
  task automatic absorb_codepoint(input logic [20:0] cp);
    if (!dec_base_seen) begin
      dec_cols = cols_for_codepoint(cp);
      dec_base_seen = 1'b1;
    end else if (cp == CP_VS16 && dec_cols == COLS_NARROW) begin
      dec_cols = COLS_WIDE;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    if (dec_pending == 2'd0) begin
      // length comes from the lead byte alone; stray continuations count as
      // two-byte leads and F8..FF as four-byte leads
      if (b < LEAD_1B_LIMIT) begin
        absorb_codepoint({13'd0, b});
      end else if (b < LEAD_2B_LIMIT) begin
        dec_cp = {16'd0, b[4:0]};
        dec_pending = 2'd1;
      end else if (b < LEAD_3B_LIMIT) begin
        dec_cp = {17'd0, b[3:0]};
        dec_pending = 2'd2;
      end else begin
        dec_cp = {18'd0, b[2:0]};
        dec_pending = 2'd3;
      end
    end else begin
      // continuation bits are taken unchecked
      dec_cp = {dec_cp[14:0], b[5:0]};
      dec_pending = dec_pending - 2'd1;
      if (dec_pending == 2'd0) absorb_codepoint(dec_cp);
    end
    if (last) begin
      // a first codepoint cut off by the cluster end reads as U+FFFD
      if (!dec_base_seen) dec_cols = COLS_NARROW;
      width_q.insert(width_q.size(), dec_cols);
      dec_pending = 2'd0;
      dec_cp = '0;
      dec_base_seen = 1'b0;
      dec_cols = COLS_ZERO;
    end
  endtask

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  // Append one byte to the cluster under construction.
  task automatic stage_byte(input logic [7:0] b);
    cluster_bytes.insert(cluster_bytes.size(), b);
  endtask

  function automatic logic [7:0] cont_byte(input logic [5:0] bits, input bit mangle);
    logic [1:0] top;
    top = mangle ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits};
  endfunction

  // Encode cp in len bytes (overlong allowed); mangle bends continuation tag bits
  // and the lead tag of two- and four-byte forms without changing the decoded value.
  task automatic add_codepoint(input logic [20:0] cp, input int len, input bit mangle);
    logic [2:0] lead_top;
    case (len)
      1: begin
        stage_byte({1'b0, cp[6:0]});
      end
      2: begin
        case ($urandom_range(0, 2))
          0: lead_top = 3'b100;
          1: lead_top = 3'b101;
          default: lead_top = 3'b110;
        endcase
        if (!mangle) lead_top = 3'b110;
        stage_byte({lead_top, cp[10:6]});
        stage_byte(cont_byte(cp[5:0], mangle));
      end
      3: begin
        stage_byte({4'b1110, cp[15:12]});
        stage_byte(cont_byte(cp[11:6], mangle));
        stage_byte(cont_byte(cp[5:0], mangle));
      end
      default: begin
        stage_byte({(mangle ? 5'b11111 : 5'b11110), cp[20:18]});
        stage_byte(cont_byte(cp[17:12], mangle));
        stage_byte(cont_byte(cp[11:6], mangle));
        stage_byte(cont_byte(cp[5:0], mangle));
      end
    endcase
  endtask

  // Move the cluster under construction onto the byte stream.
  task automatic flush_cluster(input bit hold);
    byte_xfer_t x;
    for (int i = 0; i < cluster_bytes.size(); i++) begin
      x.b = cluster_bytes[i];
      x.last = (i == cluster_bytes.size() - 1);
      x.hold = hold && (i == 0);
      byte_stream.insert(byte_stream.size(), x);
    end
    cluster_bytes.delete();
  endtask

  function automatic int min_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Codepoints biased toward the edges of the width tables.
  function automatic logic [20:0] pick_codepoint();
    logic [20:0] lo;
    logic [20:0] hi;
    int idx;
    case ($urandom_range(0, 9))
      0, 1: return 21'($urandom_range(0, 8'h7F));
      2: return 21'($urandom_range(0, 8'h1F));
      3, 4, 5: begin
        if ($urandom_range(0, 1) == 0) begin
          idx = $urandom_range(0, N_MARK - 1);
          lo = MARK_LO[idx];
          hi = MARK_HI[idx];
        end else begin
          idx = $urandom_range(0, N_DOUBLE - 1);
          lo = DOUBLE_LO[idx];
          hi = DOUBLE_HI[idx];
        end
        case ($urandom_range(0, 4))
          0: return lo - 21'd1;
          1: return lo;
          2: return hi;
          3: return hi + 21'd1;
          default: return lo + 21'($urandom_range(0, hi - lo));
        endcase
      end
      6: return CP_VS16;
      7: return 21'($urandom);
      8: return 21'($urandom_range(0, 16'h7FF));
      default: return 21'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [20:0] pick_follower();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return CP_VS16;
      4: return 21'h000300 + 21'($urandom_range(0, 8'h6F));
      default: return pick_codepoint();
    endcase
  endfunction

  task automatic add_random_cluster(input bit hold);
    int kind;
    int n_cp;
    int len;
    bit mangle;
    logic [20:0] cp;
    kind = $urandom_range(0, 19);
    len = 1;
    if (kind < 17) begin
      // mostly well-formed; a few with bent tag bits
      mangle = (kind >= 14);
      n_cp = $urandom_range(1, 4);
      for (int i = 0; i < n_cp; i++) begin
        cp = (i == 0) ? pick_codepoint() : pick_follower();
        len = min_len(cp);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(len, 4);
        add_codepoint(cp, len, mangle);
      end
      // cut the last codepoint short now and then
      if (len > 1 && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, len - 1)) void'(cluster_bytes.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 6)) stage_byte(8'($urandom));
    end
    flush_cluster(hold);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the byte stream, with random idle bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (send_idle > 0) begin
      send_idle--;
      push <= 1'b0;
    end else if (byte_stream.size() == 0) begin
      push <= 1'b0;
    end else if (byte_stream[0].hold && width_q.size() != 0) begin
      // drain point: wait for every outstanding width to be popped
      push <= 1'b0;
    end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      send_idle = $urandom_range(1, 6) - 1;
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      in_byte_in <= byte_stream[0].b;
      in_last_byte <= byte_stream[0].last;
    end
  end

  // Receiver: pop with random stall bursts, none during the tail.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (recv_idle > 0) begin
      recv_idle--;
      pop <= 1'b0;
    end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      recv_idle = $urandom_range(1, 6) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted byte feeds the predictor; every popped width is
  // compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (width_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result columns=%0d", out_columns));
        end else if (out_columns !== width_q[0]) begin
          log_mismatch($sformatf("columns got %0d exp %0d", out_columns, width_q[0]));
          void'(width_q.pop_front());
        end else begin
          void'(width_q.pop_front());
        end
      end
      if (push && !full) begin
        predict_byte(in_byte_in, in_last_byte);
        void'(byte_stream.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit mid_drain_done;
    mid_drain_done = 1'b0;

    // directed clusters
    stage_byte(8'h00);                                  // codepoint zero
    flush_cluster(1'b0);
    stage_byte(8'h41);                                  // plain ASCII
    flush_cluster(1'b0);
    stage_byte(8'h1F);                                  // control character
    flush_cluster(1'b0);
    stage_byte(8'h7F);                                  // top of one-byte range
    flush_cluster(1'b0);
    add_codepoint(21'h002764, 3, 1'b0);                 // heart + VS16 -> wide
    add_codepoint(CP_VS16, 3, 1'b0);
    flush_cluster(1'b0);
    add_codepoint(21'h004E00, 3, 1'b0);                 // CJK ideograph
    flush_cluster(1'b0);
    add_codepoint(21'h000300, 2, 1'b0);                 // combining mark alone
    flush_cluster(1'b0);
    stage_byte(8'h85);                                  // stray continuation lead
    stage_byte(8'hBF);
    flush_cluster(1'b0);
    stage_byte(8'hFF);                                  // F8..FF lead, bad conts
    repeat (3) stage_byte(8'h00);
    flush_cluster(1'b0);
    stage_byte(8'hE4);                                  // first codepoint cut off
    flush_cluster(1'b0);
    stage_byte(8'h41);                                  // later codepoint cut off
    stage_byte(8'hEF);
    stage_byte(8'hB8);
    flush_cluster(1'b0);

    // random clusters; first one and one midway wait for a full drain
    add_random_cluster(1'b1);
    while (byte_stream.size() < 1150) begin
      if (!mid_drain_done && byte_stream.size() >= 600) begin
        add_random_cluster(1'b1);
        mid_drain_done = 1'b1;
      end else begin
        add_random_cluster(1'b0);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (byte_stream.size() != 0 || width_q.size() != 0) @(posedge clk);
    // let any stray result surface
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/u8cdw_pkg.sv
rtl/u8cdw_fifo.sv
rtl/u8cdw_front.sv
rtl/u8cdw_back.sv
rtl/utf8_cluster_display_width.sv
rtl/u8cdw_checker.sv
tb/testbench.sv
